// File: sv/sha256_pkg.sv
`timescale 1ns / 1ps

package sha256_pkg;

    localparam int LENGTH_COUNTER_BITS = 64;
    localparam int COUNT_BITS = LENGTH_COUNTER_BITS - 3;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic buf_write;     // write byte at current position
        logic pad_write;     // write padding byte at pad position
        logic pad_start;     // pad position <- next free byte position
        logic pad_zero_pos;  // pad position <- 0
        logic len_write;     // write length byte
        logic load;          // schedule and working words from buffer and hash
        logic round;         // one compression round
        logic fold;          // hash += working words
        logic emit_start;    // output register takes word 0
        logic emit_next;     // next output word
        logic hash_init;     // back to initial values, count to zero
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic block_full;    // byte position wraps on this write
        logic round_last;    // round 63 in progress
        logic pad_end;       // pad position at last zero slot before length or block end
        logic pad_need_two;  // 0x80 lands beyond byte 55
        logic len_last;      // length byte 7 written
        logic out_busy;      // output register holds an item
        logic out_last;      // output register holds word 7
        logic out_taken;     // output handshake this cycle
    } dp_status_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: sv/sha256_message_hash.sv
`timescale 1ns / 1ps
// A byte that fills a block starts a compression: load, 64 rounds, fold.
// Final item: padding bytes, then eight length bytes, then one or two
// compressions; eight digest items follow, one a cycle when taken.
// Throughput: one byte item a cycle between blocks; input stalls during padding, compression and digest output.
// Reset (rst_n low, asynchronous) loads the initial hash and clears the byte count.

module sha256_message_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zeros
    output logic        m_tlast    // last_word
);

    sha256_pkg::dp_cmd_t    cmd;
    sha256_pkg::dp_status_t st;
    logic                   in_fire;
    logic [31:0]            word;
    logic [2:0]             idx;

    assign in_fire = s_tvalid && s_tready;

    sha256_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_has   (s_tuser),
        .in_last  (s_tlast),
        .st       (st),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    sha256_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (s_tdata),
        .out_ready (m_tready),
        .st        (st),
        .out_valid (m_tvalid),
        .out_word  (word),
        .out_index (idx)
    );

    assign m_tdata = {5'b0, idx, word};
    assign m_tlast = (idx == 3'd7);

    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while digest pending");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && idx == $past(idx) + 3'd1))
        else $error("digest index skipped");

    a_round_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.round && (cmd.buf_write || cmd.pad_write || cmd.len_write)))
        else $error("buffer written during rounds");

endmodule

// File: sv/sha256_ctrl.sv
`timescale 1ns / 1ps

module sha256_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_fire,
    input  logic                   in_has,
    input  logic                   in_last,
    input  sha256_pkg::dp_status_t st,
    output logic                   in_ready,
    output sha256_pkg::dp_cmd_t    cmd
);

    sha256_pkg::state_t state_reg, state_next;
    logic final_reg, final_next;     // compression belongs to final padding
    logic two_reg, two_next;         // pad run ends in block end, then second block
    logic pad_due_reg, pad_due_next; // last byte filled the block, padding follows

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sha256_pkg::ST_IDLE;
            final_reg   <= 1'b0;
            two_reg     <= 1'b0;
            pad_due_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            final_reg   <= final_next;
            two_reg     <= two_next;
            pad_due_reg <= pad_due_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        final_next   = final_reg;
        two_next     = two_reg;
        pad_due_next = pad_due_reg;
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    final_next   = in_last && !(in_has && st.block_full);
                    pad_due_next = in_last && in_has && st.block_full;
                    if (in_has && st.block_full)
                        state_next = sha256_pkg::ST_LOAD;
                    else if (in_last)
                        state_next = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_PAD:
            begin
                // first pad cycle writes 0x80; decides on one or two blocks
                two_next = two_reg || st.pad_need_two;
                if (st.pad_end)
                    state_next = (two_reg || st.pad_need_two) ? sha256_pkg::ST_LOAD
                                                              : sha256_pkg::ST_LEN;
            end
            sha256_pkg::ST_LEN:
                if (st.len_last)
                    state_next = sha256_pkg::ST_LOAD;
            sha256_pkg::ST_LOAD:
                state_next = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_ROUND:
                if (st.round_last)
                    state_next = sha256_pkg::ST_FOLD;
            sha256_pkg::ST_FOLD:
            begin
                if (pad_due_reg)
                begin
                    pad_due_next = 1'b0;
                    final_next   = 1'b1;
                    state_next   = sha256_pkg::ST_PAD;
                end
                else if (!final_reg)
                    state_next = sha256_pkg::ST_IDLE;
                else if (two_reg)
                begin
                    two_next   = 1'b0;
                    state_next = sha256_pkg::ST_PAD;
                end
                else
                    state_next = sha256_pkg::ST_EMIT;
            end
            sha256_pkg::ST_EMIT:
                if (st.out_taken && st.out_last)
                begin
                    final_next = 1'b0;
                    state_next = sha256_pkg::ST_IDLE;
                end
            default:
                state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                in_ready = !st.out_busy;
                cmd.buf_write = in_fire && in_has;
                cmd.pad_start = in_fire;
            end
            sha256_pkg::ST_PAD:
                cmd.pad_write = 1'b1;
            sha256_pkg::ST_LEN:
                cmd.len_write = 1'b1;
            sha256_pkg::ST_LOAD:
                cmd.load = 1'b1;
            sha256_pkg::ST_ROUND:
                cmd.round = 1'b1;
            sha256_pkg::ST_FOLD:
            begin
                cmd.fold         = 1'b1;
                cmd.pad_zero_pos = final_reg && two_reg;
                cmd.pad_start    = 1'b0;
                cmd.emit_start   = final_reg && !two_reg && !pad_due_reg;
            end
            sha256_pkg::ST_EMIT:
            begin
                cmd.emit_next = st.out_taken && !st.out_last;
                cmd.hash_init = st.out_taken && st.out_last;
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

// File: sv/sha256_datapath.sv
`timescale 1ns / 1ps

module sha256_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::dp_cmd_t    cmd,
    input  logic [7:0]             data_byte,
    input  logic                   out_ready,
    output sha256_pkg::dp_status_t st,
    output logic                   out_valid,
    output logic [31:0]            out_word,
    output logic [2:0]             out_index
);

    logic [31:0] block_mem [16];   // block as big-endian words
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] hash_reg [8];
    logic [sha256_pkg::COUNT_BITS-1:0] count_reg;
    logic [5:0]  round_reg;
    logic [5:0]  pad_pos_reg;
    logic        pad_marked_reg;   // 0x80 already written in this final run
    logic [2:0]  len_idx_reg;
    logic        out_valid_reg;
    logic [2:0]  out_idx_reg;
    logic [31:0] out_word_reg;
    logic [63:0] bit_len;

    assign bit_len = 64'({count_reg, 3'b000});

    // buffer writes: byte, padding, length
    always_ff @(posedge clk)
    begin
        if (cmd.buf_write)
            block_mem[count_reg[5:2]][{~count_reg[1:0], 3'b000} +: 8] <= data_byte;
        else if (cmd.pad_write)
            block_mem[pad_pos_reg[5:2]][{~pad_pos_reg[1:0], 3'b000} +: 8] <=
                pad_marked_reg ? 8'h00 : sha256_pkg::PAD_BYTE;
        else if (cmd.len_write)
            block_mem[{3'b111, len_idx_reg[2]}][{~len_idx_reg[1:0], 3'b000} +: 8] <=
                bit_len[{~len_idx_reg, 3'b000} +: 8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            round_reg      <= '0;
            pad_pos_reg    <= '0;
            pad_marked_reg <= 1'b0;
            len_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_idx_reg    <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= sha256_pkg::INIT_HASH[i];
        end
        else
        begin
            if (cmd.buf_write)
                count_reg <= count_reg + 1'b1;
            if (cmd.pad_start)
            begin
                pad_pos_reg    <= cmd.buf_write ? count_reg[5:0] + 6'd1 : count_reg[5:0];
                pad_marked_reg <= 1'b0;
            end
            else if (cmd.pad_zero_pos)
                pad_pos_reg <= '0;
            else if (cmd.pad_write)
            begin
                pad_pos_reg    <= pad_pos_reg + 6'd1;
                pad_marked_reg <= 1'b1;
            end
            if (cmd.len_write)
                len_idx_reg <= len_idx_reg + 3'd1;
            if (cmd.load)
                round_reg <= '0;
            else if (cmd.round)
                round_reg <= round_reg + 6'd1;
            if (cmd.fold)
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
            if (cmd.emit_start)
            begin
                out_valid_reg <= 1'b1;
                out_idx_reg   <= '0;
            end
            else if (cmd.emit_next)
                out_idx_reg <= out_idx_reg + 3'd1;
            else if (cmd.hash_init)
            begin
                out_valid_reg <= 1'b0;
                count_reg     <= '0;
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= sha256_pkg::INIT_HASH[i];
            end
        end
    end

    // message schedule and round
    logic [31:0] w_new, w_cur, t1, t2, s0, s1;
    always_comb
    begin
        s0 = sha256_pkg::rotr(w_reg[1], 7) ^ sha256_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = sha256_pkg::rotr(w_reg[14], 17) ^ sha256_pkg::rotr(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        w_cur = w_reg[0];
        t1 = v_reg[7] + (sha256_pkg::rotr(v_reg[4], 6) ^ sha256_pkg::rotr(v_reg[4], 11)
             ^ sha256_pkg::rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + sha256_pkg::ROUND_K[round_reg] + w_cur;
        t2 = (sha256_pkg::rotr(v_reg[0], 2) ^ sha256_pkg::rotr(v_reg[0], 13)
             ^ sha256_pkg::rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= block_mem[i];
            for (int i = 0; i < 8; i++)
                v_reg[i] <= hash_reg[i];
        end
        else if (cmd.round)
        begin
            // w_reg[0] is the word of this round; window slides by one
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (cmd.emit_start)
            out_word_reg <= hash_reg[0] + v_reg[0];
        else if (cmd.emit_next)
            out_word_reg <= hash_reg[out_idx_reg + 3'd1];
    end

    // first pad write position decides one or two blocks
    logic need_two;
    assign need_two = pad_marked_reg ? 1'b0 : (pad_pos_reg >= 6'd56);

    // a pad run stops before the length field or at the block end
    assign st.block_full   = (count_reg[5:0] == 6'd63);
    assign st.round_last   = (round_reg == 6'd63);
    assign st.pad_need_two = need_two;
    assign st.pad_end      = (pad_pos_reg == 6'd55) || (pad_pos_reg == 6'd63);
    assign st.len_last     = (len_idx_reg == 3'd7);
    assign st.out_busy     = out_valid_reg;
    assign st.out_last     = (out_idx_reg == 3'd7);
    assign st.out_taken    = out_valid_reg && out_ready;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_index = out_idx_reg;

endmodule
